// File: design/mte_pkg.sv
`default_nettype none

package mte_pkg;

    // raw range is COUNTS_PER_TURN * TURNS_PER_RANGE counts, both powers of two
    localparam int CPT_LOG2        = 10;
    localparam int TPR_LOG2        = 4;
    localparam int COUNTS_PER_TURN = 1 << CPT_LOG2;
    localparam int TURNS_PER_RANGE = 1 << TPR_LOG2;
    localparam int RAW_W           = CPT_LOG2 + TPR_LOG2;
    localparam int TURN_W          = TPR_LOG2;

    localparam logic [RAW_W-1:0] RAW_MAX  = {RAW_W{1'b1}};
    localparam logic [RAW_W:0]   RAW_HALF = (RAW_W + 1)'((COUNTS_PER_TURN * TURNS_PER_RANGE) / 2);

    // 360 degrees in 1/256 degree units
    localparam int ANGLE_PER_TURN = 92160;
    localparam int ANGLE_W        = 17;
    localparam int TANGLE_W       = 21;
    localparam int WRAP_ANGLE_W   = 22;
    localparam logic signed [WRAP_ANGLE_W-1:0] WRAP_ANGLE =
        WRAP_ANGLE_W'(ANGLE_PER_TURN * TURNS_PER_RANGE);

    localparam int ID_W     = 11;
    localparam int CMD_W    = 8;
    localparam int PAY_W    = 32;
    localparam int SLOT_W   = 2;
    localparam int WRAP_W   = 16;
    localparam int TCOUNT_W = 31;
    localparam int TANG_W   = 37;
    localparam int ERR_W    = 8;
    localparam int CNT_W    = 3;
    localparam int ADDR_W   = 3;
    localparam int NUM_IDS  = 4;

    localparam logic [CMD_W-1:0] CMD_POSITION = 8'h01;

    localparam logic signed [WRAP_W-1:0] WRAP_MAX = 16'sh7fff;
    localparam logic signed [WRAP_W-1:0] WRAP_MIN = 16'sh8000;

    typedef enum logic [ADDR_W-1:0] {
        REG_SLOT_COUNT = 3'd0,
        REG_SLOT0_ID   = 3'd1,
        REG_SLOT1_ID   = 3'd2,
        REG_SLOT2_ID   = 3'd3,
        REG_SLOT3_ID   = 3'd4
    } reg_addr_t;

    // classified frame handed from front to back
    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic                is_pos;
        logic [RAW_W-1:0]    raw;
        logic                over;
        logic [TURN_W-1:0]   turn;
        logic [TANGLE_W-1:0] tangle;
        logic [ERR_W-1:0]    err;
    } entry_t;

endpackage

`default_nettype wire

// File: design/mte_front.sv
`default_nettype none

module mte_front #(
    parameter int SLOT_COUNT_MAX = 4
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [mte_pkg::ADDR_W-1:0] cfg_addr,
    input  wire logic [mte_pkg::ID_W-1:0]   cfg_wdata,
    input  wire logic                       push,
    input  wire logic [mte_pkg::ID_W-1:0]   frame_id,
    input  wire logic [mte_pkg::CMD_W-1:0]  command_code,
    input  wire logic [mte_pkg::PAY_W-1:0]  payload,
    output logic                            q_push,
    output mte_pkg::entry_t                 q_entry
);
    import mte_pkg::*;

    logic [CNT_W-1:0] slot_count_reg;
    logic [ID_W-1:0]  slot_id_reg [NUM_IDS];

    logic [CNT_W-1:0]   used;
    logic               found;
    logic [SLOT_W-1:0]  hit_slot;
    logic               over;
    logic [RAW_W-1:0]   raw;
    logic [RAW_W+ANGLE_W-1:0] angle_prod;
    logic               is_pos;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_count_reg <= '0;
            for (int i = 0; i < NUM_IDS; i++)
            begin
                slot_id_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_SLOT_COUNT: slot_count_reg <= cfg_wdata[CNT_W-1:0];
                REG_SLOT0_ID:   slot_id_reg[0] <= cfg_wdata;
                REG_SLOT1_ID:   slot_id_reg[1] <= cfg_wdata;
                REG_SLOT2_ID:   slot_id_reg[2] <= cfg_wdata;
                REG_SLOT3_ID:   slot_id_reg[3] <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    assign used = (slot_count_reg > CNT_W'(SLOT_COUNT_MAX)) ? CNT_W'(SLOT_COUNT_MAX)
                                                            : slot_count_reg;

    // parallel id compare, lowest slot wins
    always_comb
    begin
        found    = 1'b0;
        hit_slot = '0;
        for (int s = SLOT_COUNT_MAX - 1; s >= 0; s--)
        begin
            if ((CNT_W'(s) < used) && (slot_id_reg[s] == frame_id))
            begin
                found    = 1'b1;
                hit_slot = SLOT_W'(s);
            end
        end
    end

    assign is_pos     = (command_code == CMD_POSITION);
    assign over       = |payload[PAY_W-1:RAW_W];
    assign raw        = over ? RAW_MAX : payload[RAW_W-1:0];
    assign angle_prod = raw * ANGLE_W'(ANGLE_PER_TURN);

    always_comb
    begin
        q_entry        = '0;
        q_entry.slot   = hit_slot;
        q_entry.is_pos = is_pos;
        if (is_pos)
        begin
            q_entry.raw    = raw;
            q_entry.over   = over;
            q_entry.turn   = raw[RAW_W-1:CPT_LOG2];
            q_entry.tangle = angle_prod[CPT_LOG2 +: TANGLE_W];
        end
        else
        begin
            q_entry.err = payload[ERR_W-1:0];
        end
    end

    assign q_push = push && found;

endmodule

`default_nettype wire

// File: design/mte_queue.sv
`default_nettype none

module mte_queue (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  mte_pkg::entry_t din,
    output logic            full,
    input  wire logic       pop,
    output logic            empty,
    output mte_pkg::entry_t dout
);
    import mte_pkg::*;

    entry_t      mem_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  cnt_reg;
    logic [1:0]  cnt_next;
    logic        do_push;
    logic        do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

`default_nettype wire

// File: design/mte_back.sv
`default_nettype none

module mte_back #(
    parameter int SLOT_COUNT_MAX = 4
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               q_empty,
    input  mte_pkg::entry_t                         q_head,
    output logic                                    q_pop,
    input  wire logic                               pop,
    output logic                                    empty,
    output logic        [mte_pkg::SLOT_W-1:0]       slot,
    output logic                                    is_position,
    output logic        [mte_pkg::RAW_W-1:0]        raw_value,
    output logic                                    out_of_range,
    output logic        [mte_pkg::TURN_W-1:0]       turn_index,
    output logic        [mte_pkg::TANGLE_W-1:0]     turn_angle,
    output logic signed [mte_pkg::TCOUNT_W-1:0]     total_counts,
    output logic signed [mte_pkg::TANG_W-1:0]       total_angle,
    output logic        [mte_pkg::ERR_W-1:0]        error_code
);
    import mte_pkg::*;

    localparam int IDX_W = (SLOT_COUNT_MAX > 1) ? $clog2(SLOT_COUNT_MAX) : 1;

    // per-slot tracking state
    logic [RAW_W-1:0]         last_reg [SLOT_COUNT_MAX];
    logic                     seen_reg [SLOT_COUNT_MAX];
    logic signed [WRAP_W-1:0] wrap_reg [SLOT_COUNT_MAX];

    // update stage
    logic                     s1_vld_reg;
    entry_t                   s1_entry_reg;
    logic signed [WRAP_W-1:0] s1_wrap_reg;

    // result register
    logic                     out_vld_reg;

    logic                     out_rdy;
    logic                     s1_rdy;
    logic [IDX_W-1:0]         idx;
    logic [RAW_W-1:0]         last;
    logic signed [WRAP_W-1:0] wrap_cur;
    logic signed [WRAP_W-1:0] wrap_next;
    logic signed [RAW_W:0]    diff;
    logic                     seen;
    logic                     upd;
    logic signed [TANG_W-1:0] angle_prod;

    assign out_rdy = !out_vld_reg || pop;
    assign s1_rdy  = !s1_vld_reg || out_rdy;
    assign q_pop   = !q_empty && s1_rdy;
    assign empty   = !out_vld_reg;

    assign idx      = q_head.slot[IDX_W-1:0];
    assign last     = last_reg[idx];
    assign wrap_cur = wrap_reg[idx];
    assign seen     = seen_reg[idx];
    assign diff     = $signed({1'b0, last}) - $signed({1'b0, q_head.raw});
    assign upd      = q_pop && q_head.is_pos;

    // big drop means wrapped forward, big rise means wrapped backward
    always_comb
    begin
        wrap_next = wrap_cur;
        if (seen)
        begin
            if ((diff > $signed(RAW_HALF)) && (wrap_cur != WRAP_MAX))
            begin
                wrap_next = wrap_cur + 16'sd1;
            end
            else if ((diff < -$signed(RAW_HALF)) && (wrap_cur != WRAP_MIN))
            begin
                wrap_next = wrap_cur - 16'sd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOT_COUNT_MAX; i++)
            begin
                last_reg[i] <= '0;
                seen_reg[i] <= 1'b0;
                wrap_reg[i] <= '0;
            end
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (upd)
            begin
                last_reg[idx] <= q_head.raw;
                seen_reg[idx] <= 1'b1;
                wrap_reg[idx] <= wrap_next;
            end
            if (s1_rdy)
            begin
                s1_vld_reg <= q_pop;
            end
            if (out_rdy)
            begin
                out_vld_reg <= s1_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_entry_reg <= q_head;
            s1_wrap_reg  <= q_head.is_pos ? wrap_next : '0;
        end
    end

    assign angle_prod = s1_wrap_reg * WRAP_ANGLE;

    always_ff @(posedge clk)
    begin
        if (out_rdy && s1_vld_reg)
        begin
            slot         <= s1_entry_reg.slot;
            is_position  <= s1_entry_reg.is_pos;
            raw_value    <= s1_entry_reg.raw;
            out_of_range <= s1_entry_reg.over;
            turn_index   <= s1_entry_reg.turn;
            turn_angle   <= s1_entry_reg.tangle;
            error_code   <= s1_entry_reg.err;
            if (s1_entry_reg.is_pos)
            begin
                total_counts <= {s1_wrap_reg[WRAP_W-1], s1_wrap_reg, s1_entry_reg.raw};
                total_angle  <= angle_prod
                              + $signed({{(TANG_W-TANGLE_W){1'b0}}, s1_entry_reg.tangle});
            end
            else
            begin
                total_counts <= '0;
                total_angle  <= '0;
            end
        end
    end

endmodule

`default_nettype wire

// File: design/multiturn_encoder_tracker.sv
`default_nettype none

// channel   ports                                     beat taken when
// -------   ---------------------------------------   -----------------
// config    cfg_we, cfg_addr, cfg_wdata               cfg_we
// frames    push, full, frame_id, command_code,       push && !full
//           payload
// results   pop, empty, slot .. error_code            pop && !empty
//
// one frame per cycle sustained while pop keeps the result side moving; a
// matching frame is classified into the queue at the edge that takes it,
// then goes through slot state update and result register to the result
// ports. per-slot state is read and written in the same cycle, so frames
// for the same slot can follow back to back.
// reset clears config and all slot state. a stalled result side fills the
// two-entry queue and then raises full; unmatched frames are dropped.

module multiturn_encoder_tracker #(
    parameter int SLOT_COUNT_MAX = 4
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic        [mte_pkg::ADDR_W-1:0]  cfg_addr,
    input  wire logic        [mte_pkg::ID_W-1:0]    cfg_wdata,
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic        [mte_pkg::ID_W-1:0]    frame_id,
    input  wire logic        [mte_pkg::CMD_W-1:0]   command_code,
    input  wire logic        [mte_pkg::PAY_W-1:0]   payload,
    input  wire logic                               pop,
    output logic                                    empty,
    output logic        [mte_pkg::SLOT_W-1:0]       slot,
    output logic                                    is_position,
    output logic        [mte_pkg::RAW_W-1:0]        raw_value,
    output logic                                    out_of_range,
    output logic        [mte_pkg::TURN_W-1:0]       turn_index,
    output logic        [mte_pkg::TANGLE_W-1:0]     turn_angle,
    output logic signed [mte_pkg::TCOUNT_W-1:0]     total_counts,
    output logic signed [mte_pkg::TANG_W-1:0]       total_angle,
    output logic        [mte_pkg::ERR_W-1:0]        error_code
);
    import mte_pkg::*;

    logic   fq_push;
    entry_t fq_entry;
    logic   q_full;
    logic   q_empty;
    logic   q_pop;
    entry_t q_head;

    mte_front #(
        .SLOT_COUNT_MAX (SLOT_COUNT_MAX)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .push         (push && !q_full),
        .frame_id     (frame_id),
        .command_code (command_code),
        .payload      (payload),
        .q_push       (fq_push),
        .q_entry      (fq_entry)
    );

    mte_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fq_push),
        .din   (fq_entry),
        .full  (q_full),
        .pop   (q_pop),
        .empty (q_empty),
        .dout  (q_head)
    );

    mte_back #(
        .SLOT_COUNT_MAX (SLOT_COUNT_MAX)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .pop          (pop),
        .empty        (empty),
        .slot         (slot),
        .is_position  (is_position),
        .raw_value    (raw_value),
        .out_of_range (out_of_range),
        .turn_index   (turn_index),
        .turn_angle   (turn_angle),
        .total_counts (total_counts),
        .total_angle  (total_angle),
        .error_code   (error_code)
    );

    assign full = q_full;

endmodule

`default_nettype wire
